/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the contour unit.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define MSCU_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define MSCU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* rtl/mscu_pkg.sv */
// ---------------------------------------------------------------------------
// mscu_pkg
// Types, constants and helper functions of the contour unit.
// ---------------------------------------------------------------------------
`default_nettype none
package mscu_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int D_W       = SAMPLE_W + 1;
   localparam int FRAC_W    = 8;
   localparam int COORD_W   = 18;
   localparam int DIM_W     = 11;
   localparam int IDX_W     = 10;
   localparam int MAX_DIM   = 1024;
   localparam int CNT_W     = 3;
   localparam int SUM_W     = D_W + 2;
   localparam int DATA_W    = 4 * COORD_W;

   localparam logic [1:0] REG_LEVEL  = 2'd0;
   localparam logic [1:0] REG_WIDTH  = 2'd1;
   localparam logic [1:0] REG_HEIGHT = 2'd2;

   localparam logic [FRAC_W:0] ONE_OFF = (FRAC_W + 1)'(1 << FRAC_W);

   typedef struct packed {
      logic              valid;
      logic              vertex;
      logic              interp;
      logic [1:0]        corner;
      logic [FRAC_W:0]   off;
   } cross_type;

   typedef struct packed {
      logic [COORD_W-1:0] px;
      logic [COORD_W-1:0] py;
   } point_type;

   typedef struct packed {
      logic       capture;
      logic       eval;
      logic       div_start;
      logic       div_store;
      logic       emit;
      logic       emit_sel;
      logic [1:0] edge_idx;
   } cmd_type;

   typedef struct packed {
      logic [3:0] need_div;
      logic       div_done;
      logic [1:0] nseg;
      logic       out_free;
   } status_type;

   function automatic cross_type classify(input logic signed [D_W-1:0] a,
                                          input logic signed [D_W-1:0] b,
                                          input logic [1:0] ca,
                                          input logic [1:0] cb);
      cross_type c;
      c = '0;
      if (a == 0 && b > 0) begin
         c.valid  = 1'b1;
         c.vertex = 1'b1;
         c.corner = ca;
      end else if (a > 0 && b == 0) begin
         c.valid  = 1'b1;
         c.vertex = 1'b1;
         c.corner = cb;
         c.off    = ONE_OFF;
      end else if ((a < 0 && b > 0) || (a > 0 && b < 0)) begin
         c.valid  = 1'b1;
         c.interp = 1'b1;
      end
      return c;
   endfunction

   // edge 0 bottom, 1 right, 2 top, 3 left
   function automatic point_type edge_point(input cross_type c,
                                            input logic [1:0] e,
                                            input logic [IDX_W-1:0] x0,
                                            input logic [IDX_W-1:0] y0);
      point_type p;
      logic [DIM_W-1:0] ax;
      logic [DIM_W-1:0] ay;
      logic [DIM_W+FRAC_W-1:0] fx;
      logic [DIM_W+FRAC_W-1:0] fy;
      ax = {1'b0, x0} + DIM_W'(e == 2'd1);
      ay = {1'b0, y0} + DIM_W'(e == 2'd2);
      fx = {ax, {FRAC_W{1'b0}}};
      fy = {ay, {FRAC_W{1'b0}}};
      if (e == 2'd0 || e == 2'd2) fx = fx + (DIM_W + FRAC_W)'(c.off);
      else                        fy = fy + (DIM_W + FRAC_W)'(c.off);
      p.px = fx[COORD_W-1:0];
      p.py = fy[COORD_W-1:0];
      return p;
   endfunction

endpackage
`default_nettype wire

/* rtl/mscu_ram.sv */
// ---------------------------------------------------------------------------
// mscu_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none
module mscu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

/* rtl/mscu_div.sv */
// ---------------------------------------------------------------------------
// mscu_div
// Restoring divider, one quotient bit per cycle: (na << FRAC_W) / den.
// ---------------------------------------------------------------------------
`default_nettype none
module mscu_div
   import mscu_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [D_W-1:0]    na,
   input  wire logic [D_W:0]      den,
   output logic                   done,
   output logic [FRAC_W-1:0]      quot
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [D_W+1:0]    rem_ff, rem_in;
   logic [D_W:0]      den_ff, den_in;
   logic [FRAC_W-1:0] q_ff, q_in;
   logic [D_W+1:0]    rem_sh;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      rem_sh  = {rem_ff[D_W:0], 1'b0};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = {1'b0, na};
         den_in  = den;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = rem_sh - {1'b0, den_ff};
            q_in   = {q_ff[FRAC_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            q_in   = {q_ff[FRAC_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(FRAC_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule
`default_nettype wire

/* rtl/mscu_datapath.sv */
// ---------------------------------------------------------------------------
// mscu_datapath
// Scan position, column store, corner values, crossings and result register.
// ---------------------------------------------------------------------------
`default_nettype none
module mscu_datapath
   import mscu_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire logic [SAMPLE_W-1:0] sample,
   input  wire logic                csr_we,
   input  wire logic [1:0]          csr_addr,
   input  wire logic [15:0]         csr_wdata,
   input  wire cmd_type             cmd,
   output status_type               status,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [DATA_W-1:0]        rsp_tdata,
   output logic                     rsp_tlast
);

   logic signed [SAMPLE_W-1:0] level_ff;
   logic [DIM_W-1:0]           width_ff, height_ff;
   logic [IDX_W-1:0]           col_ff, row_ff;
   logic [IDX_W-1:0]           x_ff, y_ff;
   logic signed [D_W-1:0]      d_ff, lb_ff, prev_ff;
   logic signed [D_W-1:0]      d00_ff, d10_ff, d01_ff, d11_ff;
   logic                       cell_ok_ff;
   cross_type                  cr_ff [4];
   logic                       rsp_valid_ff;
   logic [DATA_W-1:0]          rsp_data_ff;
   logic                       rsp_last_ff;

   logic [DIM_W-1:0]      w_clamp, h_clamp;
   logic signed [D_W-1:0] d_in;
   logic [D_W-1:0]        ram_rdata;
   logic signed [D_W-1:0] div_a, div_b;
   logic [D_W-1:0]        na, nb;
   logic                  div_done;
   logic [FRAC_W-1:0]     quot;
   logic [3:0]            fin;
   logic [2:0]            cnt;
   logic [1:0]            first_i, second_i;
   logic signed [SUM_W-1:0] sum;
   logic                  fence;
   logic [1:0]            s_idx, e_idx;
   point_type             ps, pe;
   logic [IDX_W-1:0]      x0, y0;

   assign w_clamp = (width_ff < DIM_W'(2)) ? DIM_W'(2) :
                    (width_ff > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : width_ff;
   assign h_clamp = (height_ff < DIM_W'(2)) ? DIM_W'(2) :
                    (height_ff > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : height_ff;
   assign d_in = D_W'(signed'(sample)) - D_W'(level_ff);

   mscu_ram #(.WIDTH(D_W), .DEPTH(MAX_DIM)) u_store (
      .clock (clock),
      .we    (cmd.capture),
      .waddr (y_ff),
      .wdata (d_ff),
      .raddr (row_ff),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff  <= '0;
         width_ff  <= DIM_W'(256);
         height_ff <= DIM_W'(256);
         col_ff    <= '0;
         row_ff    <= '0;
         lb_ff     <= '0;
         prev_ff   <= '0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               REG_LEVEL:  level_ff <= csr_wdata[SAMPLE_W-1:0];
               REG_WIDTH: begin
                  width_ff <= csr_wdata[DIM_W-1:0];
                  col_ff   <= '0;
                  row_ff   <= '0;
               end
               REG_HEIGHT: begin
                  height_ff <= csr_wdata[DIM_W-1:0];
                  col_ff    <= '0;
                  row_ff    <= '0;
               end
               default: ;
            endcase
         end else if (accept) begin
            if ({1'b0, row_ff} + DIM_W'(1) >= h_clamp) begin
               row_ff <= '0;
               col_ff <= ({1'b0, col_ff} + DIM_W'(1) >= w_clamp) ? '0 : col_ff + 1'b1;
            end else begin
               row_ff <= row_ff + 1'b1;
            end
         end
         if (cmd.capture) begin
            lb_ff   <= ram_rdata;
            prev_ff <= d_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         d_ff       <= d_in;
         x_ff       <= col_ff;
         y_ff       <= row_ff;
         cell_ok_ff <= (col_ff != '0) && (row_ff != '0);
      end
      if (cmd.capture) begin
         d00_ff <= lb_ff;
         d10_ff <= prev_ff;
         d01_ff <= ram_rdata;
         d11_ff <= d_ff;
      end
      if (cmd.eval) begin
         cr_ff[0] <= classify(d00_ff, d10_ff, 2'd0, 2'd1);
         cr_ff[1] <= classify(d10_ff, d11_ff, 2'd1, 2'd3);
         cr_ff[2] <= classify(d01_ff, d11_ff, 2'd2, 2'd3);
         cr_ff[3] <= classify(d00_ff, d01_ff, 2'd0, 2'd2);
      end else if (cmd.div_store) begin
         cr_ff[cmd.edge_idx].off <= {1'b0, quot};
      end
   end

   always_comb begin
      case (cmd.edge_idx)
         2'd0:    begin div_a = d00_ff; div_b = d10_ff; end
         2'd1:    begin div_a = d10_ff; div_b = d11_ff; end
         2'd2:    begin div_a = d01_ff; div_b = d11_ff; end
         default: begin div_a = d00_ff; div_b = d01_ff; end
      endcase
      na = div_a[D_W-1] ? D_W'(-div_a) : D_W'(div_a);
      nb = div_b[D_W-1] ? D_W'(-div_b) : D_W'(div_b);
   end

   mscu_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .na    (na),
      .den   ({1'b0, na} + {1'b0, nb}),
      .done  (div_done),
      .quot  (quot)
   );

   // vertex crossings shared by adjacent edges cancel
   always_comb begin
      fin = '0;
      for (int i = 0; i < 4; i++) fin[i] = cr_ff[i].valid;
      for (int i = 0; i < 3; i++) begin
         if (fin[i] && cr_ff[i].vertex) begin
            for (int j = 3; j > i; j--) begin
               if (fin[j] && cr_ff[j].vertex && cr_ff[j].corner == cr_ff[i].corner
                   && fin[i]) begin
                  fin[i] = 1'b0;
                  fin[j] = 1'b0;
               end
            end
         end
      end
      cnt = 3'(fin[0]) + 3'(fin[1]) + 3'(fin[2]) + 3'(fin[3]);
      first_i  = fin[0] ? 2'd0 : fin[1] ? 2'd1 : 2'd2;
      second_i = (fin[3] && !(fin[0] && fin[1]) && !(fin[0] && fin[2])
                  && !(fin[1] && fin[2])) ? 2'd3 :
                 (fin[2] && (fin[0] || fin[1])) ? 2'd2 : 2'd1;
   end

   assign sum = SUM_W'(d00_ff) + SUM_W'(d10_ff) + SUM_W'(d01_ff) + SUM_W'(d11_ff);
   assign fence = (d00_ff == 0) || (sum == 0) || (d00_ff[D_W-1] != sum[SUM_W-1]);

   always_comb begin
      if (cnt == 3'd4) begin
         if (cmd.emit_sel) begin
            s_idx = fence ? 2'd1 : 2'd2;
            e_idx = fence ? 2'd2 : 2'd3;
         end else begin
            s_idx = 2'd0;
            e_idx = fence ? 2'd3 : 2'd1;
         end
      end else begin
         s_idx = first_i;
         e_idx = second_i;
      end
   end

   assign x0 = x_ff - 1'b1;
   assign y0 = y_ff - 1'b1;
   assign ps = edge_point(cr_ff[s_idx], s_idx, x0, y0);
   assign pe = edge_point(cr_ff[e_idx], e_idx, x0, y0);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.emit) begin
         rsp_data_ff <= {pe.py, pe.px, ps.py, ps.px};
         rsp_last_ff <= (cnt != 3'd4) || cmd.emit_sel;
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) status.need_div[i] = cr_ff[i].interp;
      status.div_done = div_done;
      status.nseg     = !cell_ok_ff ? 2'd0 : (cnt == 3'd2) ? 2'd1 :
                        (cnt == 3'd4) ? 2'd2 : 2'd0;
      status.out_free = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
`default_nettype wire

/* rtl/mscu_ctrl.sv */
// ---------------------------------------------------------------------------
// mscu_ctrl
// Sequencer: capture, crossing test, per-edge division, segment output.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module mscu_ctrl
   import mscu_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   output logic            accept,
   output cmd_type         cmd,
   input  wire status_type status
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_EVAL  = 3'd2;
   localparam logic [2:0] S_SCAN  = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;
   localparam logic [2:0] S_EMIT0 = 3'd5;
   localparam logic [2:0] S_EMIT1 = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [1:0] edge_ff, edge_in;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in     = state_ff;
      edge_in      = edge_ff;
      cmd          = '0;
      cmd.edge_idx = edge_ff;
      case (state_ff)
         S_IDLE:  if (accept) state_in = S_READ;
         S_READ: begin
            cmd.capture = 1'b1;
            state_in    = S_EVAL;
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            edge_in  = 2'd0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (status.need_div[edge_ff]) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else if (edge_ff == 2'd3) begin
               state_in = S_EMIT0;
            end else begin
               edge_in = edge_ff + 1'b1;
            end
         end
         S_DIV: begin
            if (status.div_done) begin
               cmd.div_store = 1'b1;
               if (edge_ff == 2'd3) begin
                  state_in = S_EMIT0;
               end else begin
                  edge_in  = edge_ff + 1'b1;
                  state_in = S_SCAN;
               end
            end
         end
         S_EMIT0: begin
            if (status.nseg == 2'd0) begin
               state_in = S_IDLE;
            end else if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = (status.nseg == 2'd2) ? S_EMIT1 : S_IDLE;
            end
         end
         S_EMIT1: begin
            cmd.emit_sel = 1'b1;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         edge_ff  <= '0;
      end else begin
         state_ff <= state_in;
         edge_ff  <= edge_in;
      end
   end

   `MSCU_ASSERT_NEXT(a_accept_reads, clock, reset, accept, state_ff == S_READ)
   `MSCU_ASSERT_NOW(a_emit1_two, clock, reset, state_ff == S_EMIT1, status.nseg == 2'd2)
   `MSCU_ASSERT_NOW(a_div_needed, clock, reset, cmd.div_start, status.need_div[edge_ff])

endmodule
`default_nettype wire

/* rtl/marching_squares_contour_unit.sv */
// Each sample runs through capture, crossing test, one division per interpolated
// edge on the shared bit-serial divider, and segment output, which waits for a free
// output register; the next sample is taken only after that. A segment waiting in
// the output register does not block the next sample. Reset: synchronous, active
// high; clears scan position and registers to level 0, 256 x 256 grid; column store
// not cleared.
`default_nettype none
module marching_squares_contour_unit
   import mscu_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [SAMPLE_W-1:0] req_tdata,   // sample
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [DATA_W-1:0]        rsp_tdata,   // start_x, start_y, end_x, end_y
   output logic                     rsp_tlast,   // last_in_cell
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [1:0]          csr_addr,
   input  wire logic [15:0]         csr_wdata
);

   cmd_type    cmd;
   status_type status;
   logic       accept;

   assign csr_ready = 1'b1;

   mscu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .accept     (accept),
      .cmd        (cmd),
      .status     (status)
   );

   mscu_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .sample     (req_tdata),
      .csr_we     (csr_valid),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire
